// ----- sv/quadratic_residue_prng_defines.svh -----
// Assertion macros used by the RTL of the quadratic-residue generator.
`ifndef QUADRATIC_RESIDUE_PRNG_DEFINES_SVH
`define QUADRATIC_RESIDUE_PRNG_DEFINES_SVH

// Clocked check, muted while reset is applied.
`define QRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define QRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/qrp_pkg.sv -----
// Constants, codes and helpers of the quadratic-residue generator.
`timescale 1ns / 1ps
package qrp_pkg;

  localparam int NUM_OFFSETS = 8;
  localparam int MIX_PASSES  = 4;

  localparam int IDX_W  = (NUM_OFFSETS > 1) ? $clog2(NUM_OFFSETS) : 1;
  localparam int PASS_W = (MIX_PASSES > 1) ? $clog2(MIX_PASSES) : 1;

  localparam int WORD_W = 32;
  localparam int DRAW_W = 64;

  localparam logic [WORD_W-1:0] QR_PRIME   = 32'd4294967291;
  localparam logic [WORD_W-1:0] QR_HALF    = 32'd2147483645;
  localparam logic [WORD_W-1:0] QR_XOR_KEY = 32'h5bf03635;

  localparam logic [2:0] OP_SEED   = 3'd0;
  localparam logic [2:0] OP_MIX    = 3'd1;
  localparam logic [2:0] OP_GEN32  = 3'd2;
  localparam logic [2:0] OP_GEN32U = 3'd3;
  localparam logic [2:0] OP_GEN64  = 3'd4;
  localparam logic [2:0] OP_RANGE  = 3'd5;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 64;

  typedef logic [DRAW_W-1:0] draw_t;

endpackage

// ----- sv/qrp_div.sv -----
// Restoring divider, one quotient bit a cycle, remainder only.
`timescale 1ns / 1ps
module qrp_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  qrp_pkg::draw_t   dividend,
  input  qrp_pkg::draw_t   divisor,
  output logic             done,
  output qrp_pkg::draw_t   remainder
);
  import qrp_pkg::*;

  localparam int CNT_W = $clog2(DRAW_W) + 1;

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  draw_t             rem_r;
  draw_t             quo_r;
  draw_t             dsr_r;
  logic              done_r;
  logic [DRAW_W:0]   trial;
  logic [DRAW_W:0]   diff;

  assign trial = {rem_r, quo_r[DRAW_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DRAW_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // The partial remainder stays below the divisor, so 64 bits hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= diff[DRAW_W] ? trial[DRAW_W-1:0] : diff[DRAW_W-1:0];
      quo_r <= {quo_r[DRAW_W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ----- sv/quadratic_residue_prng.sv -----
// Top level of the quadratic-residue permutation random generator.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-----------------------------------
//   in_     | in  | in_tvalid/in_tready   | op, seed_index, seed_word,
//           |     |                       | lower_bound, upper_bound
//   out_    | out | out_tvalid/out_tready | random_word
//
// A seed load writes the offset memory and leaves the FSM idle. Every keyed
// step passes through the shared square-and-reduce unit in S_MUL (square),
// then S_RED (fold mod 2^32-5 with the offset read back from the offset
// memory); a 32-bit draw runs one step per offset, a 64-bit draw two such
// chains, and a mix one chain per pass. A range draw also passes through the
// divider unless the range difference is zero. A result waits in S_OUT until
// the output register is free, then is loaded into it and the FSM goes idle.
// Reset (rst_n low, synchronous) zeroes the offsets through per-entry valid
// bits and clears the running value; no clearing pass is needed.
// One item is worked at a time; a finished result waits in the output
// register, and the next item is accepted while it waits.
`timescale 1ns / 1ps
`include "quadratic_residue_prng_defines.svh"
module quadratic_residue_prng (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] op, [5:3] seed_index, [37:6] seed_word, [101:38] lower_bound,
  // [165:102] upper_bound, [167:166] zero
  input  logic [qrp_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] random_word
  output logic [qrp_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import qrp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Unpack the input item.
  logic [2:0]        in_op;
  logic [2:0]        in_seed_index;
  logic [WORD_W-1:0] in_seed_word;
  draw_t             in_lower_bound;
  draw_t             in_upper_bound;

  assign in_op          = in_tdata[2:0];
  assign in_seed_index  = in_tdata[5:3];
  assign in_seed_word   = in_tdata[37:6];
  assign in_lower_bound = in_tdata[101:38];
  assign in_upper_bound = in_tdata[165:102];

  logic [2:0]        state_r;
  logic [2:0]        op_r;
  logic [IDX_W-1:0]  k_r;
  logic [PASS_W-1:0] pass_r;
  logic              carry_r;
  logic              second_r;
  logic [WORD_W-1:0] x_r;
  logic [WORD_W-1:0] run_r;
  logic [WORD_W-1:0] hi_r;
  draw_t             lower_r;
  draw_t             upper_r;
  draw_t             res_r;
  logic              ineg_r;
  logic              out_valid_r;
  draw_t             out_data_r;

  // Offset memory: one write port, one registered read port.
  logic [WORD_W-1:0] offs_mem [NUM_OFFSETS];
  logic [NUM_OFFSETS-1:0] vld_r;
  logic [WORD_W-1:0] rd_q_r;
  logic              rd_vld_r;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      offs_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= offs_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[k_r];
    end
  end

  // An entry never written reads as its reset value of zero.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

  // Square and reduce mod 2^32-5: 2^32 is congruent to 5, so fold twice.
  logic [2*WORD_W-1:0] sq_r;
  logic                big_r;
  logic                upper_half_r;
  logic [35:0]         fold1;
  logic [32:0]         fold2;
  logic [32:0]         fold2_sub;
  logic [WORD_W-1:0]   res_mod;
  logic [WORD_W-1:0]   perm;
  logic [WORD_W-1:0]   new_x;
  logic [WORD_W-1:0]   off_inc;

  assign fold1     = {2'b00, sq_r[63:32], 2'b00} + {4'b0000, sq_r[63:32]}
                   + {4'b0000, sq_r[31:0]};
  assign fold2     = {27'd0, fold1[35:32], 2'b00} + {29'd0, fold1[35:32]}
                   + {1'b0, fold1[31:0]};
  assign fold2_sub = fold2 - {1'b0, QR_PRIME};
  assign res_mod   = fold2_sub[32] ? fold2[31:0] : fold2_sub[31:0];
  assign perm      = big_r ? x_r : (upper_half_r ? (QR_PRIME - res_mod) : res_mod);
  assign new_x     = (perm + rd_data) ^ QR_XOR_KEY;
  assign off_inc   = rd_data + 1'b1;

  logic last_k;
  logic last_pass;
  logic two_draws;
  assign last_k    = (k_r == IDX_W'(NUM_OFFSETS - 1));
  assign last_pass = (pass_r == PASS_W'(MIX_PASSES - 1));
  assign two_draws = (op_r == OP_GEN64) || (op_r == OP_RANGE);

  // Range arithmetic around the divider.
  draw_t diff_d;
  draw_t div_a;
  draw_t div_b;
  draw_t div_rem;
  draw_t u_draw;
  logic  div_start;
  logic  div_done;

  assign u_draw = {hi_r, new_x};
  assign diff_d = upper_r - lower_r + 1'b1;
  assign div_a  = u_draw[DRAW_W-1] ? (draw_t'(0) - u_draw) : u_draw;
  assign div_b  = diff_d[DRAW_W-1] ? (draw_t'(0) - diff_d) : diff_d;

  qrp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .remainder (div_rem)
  );

  logic in_acc;
  logic out_free;
  logic seed_ok;
  logic draw_end;
  logic out_load;

  // Hold off the input while reset is applied.
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == S_OUT) && out_free;
  assign seed_ok   = ({2'b00, in_seed_index} < 5'(NUM_OFFSETS));
  assign draw_end  = (state_r == S_RED) && last_k && (op_r != OP_MIX);

  assign div_start = draw_end && (op_r == OP_RANGE) && second_r && (diff_d != '0);

  // Write port: seed loads while idle, mix results and counter steps on reduce.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_r;
    wr_data = new_x;
    if (in_acc && (in_op == OP_SEED)) begin
      wr_en   = seed_ok;
      wr_addr = IDX_W'(in_seed_index);
      wr_data = in_seed_word;
    end else if (state_r == S_RED) begin
      case (op_r)
        OP_MIX: begin
          wr_en = 1'b1;
        end
        OP_GEN32, OP_GEN64, OP_RANGE: begin
          wr_en   = carry_r;
          wr_data = off_inc;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      pass_r      <= '0;
      carry_r     <= 1'b1;
      second_r    <= 1'b0;
      op_r        <= OP_SEED;
    end else begin
      // Load a new result, or drop the one just taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_op;
            k_r      <= '0;
            pass_r   <= '0;
            carry_r  <= 1'b1;
            second_r <= 1'b0;
            x_r      <= (in_op == OP_MIX) ? '0 : run_r;
            lower_r  <= in_lower_bound;
            upper_r  <= in_upper_bound;
            case (in_op)
              OP_MIX: begin
                run_r   <= '0;
                state_r <= S_MUL;
              end
              OP_GEN32U: begin
                run_r   <= run_r + 1'b1;
                state_r <= S_MUL;
              end
              OP_GEN32, OP_GEN64, OP_RANGE: begin
                state_r <= S_MUL;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL: begin
          sq_r         <= x_r * x_r;
          big_r        <= (x_r >= QR_PRIME);
          upper_half_r <= (x_r > QR_HALF);
          state_r      <= S_RED;
        end
        S_RED: begin
          x_r <= new_x;
          k_r <= last_k ? '0 : (k_r + 1'b1);
          if (!last_k) begin
            state_r <= S_MUL;
            if (carry_r) begin
              carry_r <= (off_inc == '0);
            end
          end else if (op_r == OP_MIX) begin
            pass_r  <= pass_r + 1'b1;
            state_r <= last_pass ? S_IDLE : S_MUL;
          end else begin
            if (op_r != OP_GEN32U) begin
              run_r <= new_x;
            end
            if (two_draws && !second_r) begin
              // Hold the high word, restart the chain for the low word.
              second_r <= 1'b1;
              carry_r  <= 1'b1;
              hi_r     <= new_x;
              state_r  <= S_MUL;
            end else if (op_r == OP_RANGE) begin
              ineg_r <= u_draw[DRAW_W-1];
              if (diff_d == '0) begin
                res_r   <= u_draw;
                state_r <= S_OUT;
              end else begin
                state_r <= S_DIV;
              end
            end else if (op_r == OP_GEN64) begin
              res_r   <= u_draw;
              state_r <= S_OUT;
            end else begin
              res_r   <= {{WORD_W{1'b0}}, new_x};
              state_r <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= (ineg_r ? (draw_t'(0) - div_rem) : div_rem) + lower_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic op_has_result;
  assign op_has_result = op_r inside {OP_GEN32, OP_GEN32U, OP_GEN64, OP_RANGE};

  `QRP_ASSERT(a_red_after_mul, (state_r == S_RED) |-> ($past(state_r) == S_MUL), "lone reduce")
  `QRP_ASSERT(a_div_done_in_div, div_done |-> (state_r == S_DIV), "divider done outside divide")
  `QRP_ASSERT(a_out_only_result_ops, (state_r == S_OUT) |-> op_has_result, "result for no-result op")
  `QRP_ASSERT(a_seed_no_leave_idle, (in_acc && (in_op == OP_SEED)) |=> (state_r == S_IDLE), "seed left idle")

endmodule
